@@ hw/rtl/tsbq_pkg.sv @@
// Shared types and constants for the SYN backlog queue.
`default_nettype none

package tsbq_pkg;

    // Operation codes carried on s_tuser
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TAKE   = 1'b1;

    // SYN bit position in the TCP flag byte
    localparam int SYN_BIT_POS = 1;

    // Input word layout (s_tdata)
    localparam int IN_FLAGS_LSB = 0;
    localparam int IN_PORT_LSB  = 8;
    localparam int IN_ADDR_LSB  = 24;
    localparam int IN_SEQ_LSB   = 56;
    localparam int IN_MSSP_LSB  = 88;
    localparam int IN_MSS_LSB   = 89;
    localparam int IN_TDATA_W   = 112;

    // Output word layout (m_tdata)
    localparam int OUT_ACC_LSB  = 0;
    localparam int OUT_STO_LSB  = 1;
    localparam int OUT_FND_LSB  = 2;
    localparam int OUT_PORT_LSB = 3;
    localparam int OUT_ADDR_LSB = 19;
    localparam int OUT_RCV_LSB  = 51;
    localparam int OUT_MSS_LSB  = 83;
    localparam int OUT_TDATA_W  = 104;

    // Slot word layout in the slot memory: {port, addr, rcv_next, mss}
    localparam int SLOT_MSS_LSB  = 0;
    localparam int SLOT_RCV_LSB  = 16;
    localparam int SLOT_ADDR_LSB = 48;
    localparam int SLOT_PORT_LSB = 80;
    localparam int SLOT_W        = 96;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_RESP
    } state_t;

    // Controls from the sequencer to the datapath
    typedef struct packed {
        logic mem_we;
        logic mem_re;
        logic res_load;
        logic accepted;
        logic stored;
        logic found;
    } ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/tsbq_slot_ram.sv @@
// Slot memory: one write port, one registered read port.
`default_nettype none

module tsbq_slot_ram #(
    parameter int DEPTH = 4,
    parameter int IDX_W = 2,
    parameter int WIDTH = 96
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [IDX_W-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tsbq_seq.sv @@
// Sequencer: occupancy bits, write pointer and the one-slot-per-cycle scan.
`default_nettype none

module tsbq_seq #(
    parameter int DEPTH = 4,
    parameter int IDX_W = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             in_op,
    input  wire logic             in_syn,
    input  wire logic             in_port_nz,
    input  wire logic             out_free,
    output logic      [IDX_W-1:0] wr_idx,
    output logic      [IDX_W-1:0] rd_idx,
    output tsbq_pkg::ctl_t        ctl
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    tsbq_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] wp_reg, wp_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic             accepted_reg, accepted_next;
    logic             stored_reg, stored_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] wp_inc;
    logic [IDX_W-1:0] idx_inc;

    // circular incrementers for the write pointer and the scan index
    assign wp_inc  = (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;
    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tsbq_pkg::ST_IDLE;
            wp_reg       <= '0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            valid_reg    <= '0;
            accepted_reg <= 1'b0;
            stored_reg   <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            idx_reg      <= idx_next;
            cnt_reg      <= cnt_next;
            valid_reg    <= valid_next;
            accepted_reg <= accepted_next;
            stored_reg   <= stored_next;
            found_reg    <= found_next;
        end
    end

    // next state and outputs
    always_comb begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        valid_next    = valid_reg;
        accepted_next = accepted_reg;
        stored_next   = stored_reg;
        found_next    = found_reg;
        in_ready      = 1'b0;
        ctl           = '0;

        unique case (state_reg)
            tsbq_pkg::ST_IDLE: begin
                // not ready while reset is held
                in_ready = aresetn;
                if (in_valid && aresetn) begin
                    accepted_next = 1'b0;
                    stored_next   = 1'b0;
                    found_next    = 1'b0;
                    if (in_op == tsbq_pkg::OP_ARRIVE) begin
                        // arrival: store into the slot at the write pointer if free
                        state_next = tsbq_pkg::ST_RESP;
                        if (in_syn && in_port_nz) begin
                            accepted_next = 1'b1;
                            if (!valid_reg[wp_reg]) begin
                                ctl.mem_we         = 1'b1;
                                valid_next[wp_reg] = 1'b1;
                                wp_next            = wp_inc;
                                stored_next        = 1'b1;
                            end
                        end
                    end else begin
                        // take: scan starts one past the write pointer
                        idx_next   = wp_inc;
                        cnt_next   = '0;
                        state_next = tsbq_pkg::ST_SCAN;
                    end
                end
            end
            tsbq_pkg::ST_SCAN: begin
                if (valid_reg[idx_reg]) begin
                    ctl.mem_re          = 1'b1;
                    valid_next[idx_reg] = 1'b0;
                    found_next          = 1'b1;
                    state_next          = tsbq_pkg::ST_READ;
                end else if (cnt_reg == LAST_IDX) begin
                    state_next = tsbq_pkg::ST_RESP;
                end else begin
                    idx_next = idx_inc;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            tsbq_pkg::ST_READ: begin
                state_next = tsbq_pkg::ST_RESP;
            end
            tsbq_pkg::ST_RESP: begin
                if (out_free) begin
                    ctl.res_load = 1'b1;
                    state_next   = tsbq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tsbq_pkg::ST_IDLE;
            end
        endcase

        ctl.accepted = accepted_reg;
        ctl.stored   = stored_reg;
        ctl.found    = found_reg;
    end

    assign wr_idx = wp_reg;
    assign rd_idx = idx_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tcp_syn_backlog_queue.sv @@
// Top level of the TCP SYN backlog queue: slot store, sequencer, result register.
//
//  channel | ports           | word
//  --------+-----------------+------------------------------------------------
//  input   | s_tvalid/tready | tuser: op; tdata: arrival fields
//  result  | m_tvalid/tready | tdata: accepted, stored, found, returned entry
//
//  An arrival goes from acceptance straight to loading the result. A take runs
//  a scan in which the sequencer tests one occupancy bit per cycle around the
//  ring, then reads the slot memory and loads the result.
//  Reset empties all slots and zeroes the write pointer; slot data is not cleared.
//  A result waits in the output register while m_tready is low; the next word
//  is accepted meanwhile and its result waits until the register frees.
`default_nettype none

module tcp_syn_backlog_queue #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // op
    input  wire logic [0:0]                         s_tuser,
    // tcp_flags, peer_port, peer_addr, seq_number, mss_present, mss_value
    input  wire logic [tsbq_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // accepted, stored, found, out_port, out_addr, out_rcv_next, out_mss
    output logic      [tsbq_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    tsbq_pkg::ctl_t                      ctl;
    logic [IDX_W-1:0]                    wr_idx;
    logic [IDX_W-1:0]                    rd_idx;
    logic [tsbq_pkg::SLOT_W-1:0]         slot_wdata;
    logic [tsbq_pkg::SLOT_W-1:0]         slot_rdata;
    logic [15:0]                         in_port;
    logic [31:0]                         in_addr;
    logic [31:0]                         in_seq;
    logic                                in_mss_present;
    logic [15:0]                         in_mss;
    logic [7:0]                          in_flags;
    logic                                out_free;
    logic                                m_tvalid_reg;
    logic [tsbq_pkg::OUT_TDATA_W-1:0]    m_tdata_reg;
    logic [tsbq_pkg::OUT_TDATA_W-1:0]    m_tdata_next;

    // input field unpack
    assign in_flags       = s_tdata[tsbq_pkg::IN_FLAGS_LSB +: 8];
    assign in_port        = s_tdata[tsbq_pkg::IN_PORT_LSB +: 16];
    assign in_addr        = s_tdata[tsbq_pkg::IN_ADDR_LSB +: 32];
    assign in_seq         = s_tdata[tsbq_pkg::IN_SEQ_LSB +: 32];
    assign in_mss_present = s_tdata[tsbq_pkg::IN_MSSP_LSB];
    assign in_mss         = s_tdata[tsbq_pkg::IN_MSS_LSB +: 16];

    // slot word: rcv_next is seq + 1, MSS zero when the option is absent
    assign slot_wdata = {in_port, in_addr, in_seq + 32'd1,
                         (in_mss_present ? in_mss : 16'd0)};

    assign out_free = !m_tvalid_reg || m_tready;

    tsbq_seq #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser[0]),
        .in_syn     (in_flags[tsbq_pkg::SYN_BIT_POS]),
        .in_port_nz (in_port != 16'd0),
        .out_free   (out_free),
        .wr_idx     (wr_idx),
        .rd_idx     (rd_idx),
        .ctl        (ctl)
    );

    tsbq_slot_ram #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W),
        .WIDTH (tsbq_pkg::SLOT_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ctl.mem_we),
        .waddr (wr_idx),
        .wdata (slot_wdata),
        .re    (ctl.mem_re),
        .raddr (rd_idx),
        .rdata (slot_rdata)
    );

    // result word: returned entry only when a slot was found
    always_comb begin
        m_tdata_next = '0;
        m_tdata_next[tsbq_pkg::OUT_ACC_LSB] = ctl.accepted;
        m_tdata_next[tsbq_pkg::OUT_STO_LSB] = ctl.stored;
        m_tdata_next[tsbq_pkg::OUT_FND_LSB] = ctl.found;
        if (ctl.found) begin
            m_tdata_next[tsbq_pkg::OUT_PORT_LSB +: 16] =
                slot_rdata[tsbq_pkg::SLOT_PORT_LSB +: 16];
            m_tdata_next[tsbq_pkg::OUT_ADDR_LSB +: 32] =
                slot_rdata[tsbq_pkg::SLOT_ADDR_LSB +: 32];
            m_tdata_next[tsbq_pkg::OUT_RCV_LSB +: 32] =
                slot_rdata[tsbq_pkg::SLOT_RCV_LSB +: 32];
            m_tdata_next[tsbq_pkg::OUT_MSS_LSB +: 16] =
                slot_rdata[tsbq_pkg::SLOT_MSS_LSB +: 16];
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctl.res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (ctl.res_load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the TCP SYN backlog queue: directed table, random words, scoreboard.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SLOTS = 4;
    localparam int LONG_HOLD  = 200;
    localparam int QUIET_MAX  = 2000;
    localparam int DRAIN_WAIT = 20;

    // One input word, split into its fields
    typedef struct packed {
        logic        op;
        logic [7:0]  flags;
        logic [15:0] port;
        logic [31:0] addr;
        logic [31:0] seq;
        logic        mss_on;
        logic [15:0] mss;
    } syn_req_t;

    // One result word, split into its fields
    typedef struct packed {
        logic        accepted;
        logic        stored;
        logic        found;
        logic [15:0] port;
        logic [31:0] addr;
        logic [31:0] rcv_next;
        logic [15:0] mss;
    } backlog_res_t;

    // Directed row: word to send, and a hand-written result where one is given
    typedef struct packed {
        syn_req_t     req;
        logic         typed;
        backlog_res_t res;
    } dir_row_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [0:0]                       s_tuser  = '0;
    logic [tsbq_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [tsbq_pkg::OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the ring
    int          wr_slot;
    logic [15:0] ring_port     [RING_SLOTS];
    logic [31:0] ring_addr     [RING_SLOTS];
    logic [31:0] ring_rcv_next [RING_SLOTS];
    logic [15:0] ring_mss      [RING_SLOTS];

    backlog_res_t awaited_replies [$];
    dir_row_t     dir_tab [$];
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;
    int           tx_gap_pct     = 0;
    int           rx_gap_pct     = 0;
    logic         hold_req       = 1'b0;
    logic         hold_taken     = 1'b0;
    int           hold_left      = 0;

    tcp_syn_backlog_queue #(.QUEUE_DEPTH(RING_SLOTS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic syn_req_t mk_req(logic op, logic [7:0] flags, logic [15:0] port,
                                        logic [31:0] addr, logic [31:0] seq,
                                        logic mss_on, logic [15:0] mss);
        syn_req_t r;
        r.op = op; r.flags = flags; r.port = port; r.addr = addr;
        r.seq = seq; r.mss_on = mss_on; r.mss = mss;
        return r;
    endfunction

    function automatic backlog_res_t mk_res(logic acc, logic sto, logic fnd, logic [15:0] port,
                                            logic [31:0] addr, logic [31:0] rcv,
                                            logic [15:0] mss);
        backlog_res_t r;
        r.accepted = acc; r.stored = sto; r.found = fnd; r.port = port;
        r.addr = addr; r.rcv_next = rcv; r.mss = mss;
        return r;
    endfunction

    function automatic logic [tsbq_pkg::IN_TDATA_W-1:0] pack_req(syn_req_t r);
        logic [tsbq_pkg::IN_TDATA_W-1:0] w;
        w = '0;
        w[tsbq_pkg::IN_FLAGS_LSB +: 8] = r.flags;
        w[tsbq_pkg::IN_PORT_LSB  +: 16] = r.port;
        w[tsbq_pkg::IN_ADDR_LSB  +: 32] = r.addr;
        w[tsbq_pkg::IN_SEQ_LSB   +: 32] = r.seq;
        w[tsbq_pkg::IN_MSSP_LSB]        = r.mss_on;
        w[tsbq_pkg::IN_MSS_LSB   +: 16] = r.mss;
        return w;
    endfunction

    // Ring behavior: returns the result of one word and updates the shadow copy
    function automatic backlog_res_t backlog_predict(syn_req_t r);
        backlog_res_t res;
        int           slot;
        res = '0;
        if (r.op == tsbq_pkg::OP_ARRIVE) begin
            // segments without SYN or with port zero are ignored
            if (!r.flags[tsbq_pkg::SYN_BIT_POS] || r.port == 16'd0)
                return res;
            res.accepted = 1'b1;
            // occupied target slot: drop, pointer stays
            if (ring_port[wr_slot] != 16'd0)
                return res;
            ring_port[wr_slot]     = r.port;
            ring_addr[wr_slot]     = r.addr;
            ring_rcv_next[wr_slot] = r.seq + 32'd1;
            ring_mss[wr_slot]      = r.mss_on ? r.mss : 16'd0;
            wr_slot = (wr_slot + 1) % RING_SLOTS;
            res.stored = 1'b1;
        end else begin
            // oldest entry: scan from pointer plus one around to the pointer
            for (int i = 1; i <= RING_SLOTS; i++) begin
                slot = (wr_slot + i) % RING_SLOTS;
                if (ring_port[slot] != 16'd0) begin
                    res.found    = 1'b1;
                    res.port     = ring_port[slot];
                    res.addr     = ring_addr[slot];
                    res.rcv_next = ring_rcv_next[slot];
                    res.mss      = ring_mss[slot];
                    ring_port[slot] = 16'd0;
                    break;
                end
            end
        end
        return res;
    endfunction

    function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Send one word; the sender may idle first. tvalid stays high after acceptance.
    task automatic send_req(syn_req_t r, logic typed, backlog_res_t typed_res);
        backlog_res_t pred;
        if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= pack_req(r);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = backlog_predict(r);
        awaited_replies.push_back(typed ? typed_res : pred);
    endtask

    function automatic syn_req_t rand_req();
        syn_req_t r;
        r.op     = 1'($urandom_range(1));
        r.flags  = 8'($urandom_range(255));
        r.port   = 16'($urandom_range(65535));
        r.addr   = $urandom;
        r.seq    = $urandom;
        r.mss_on = 1'($urandom_range(1));
        r.mss    = 16'($urandom_range(65535));
        case ($urandom_range(9))
            0: r.port = 16'hFFFF;
            1: r.seq  = 32'hFFFF_FFFF;
            default: ;
        endcase
        return r;
    endfunction

    // Random words: arrival-heavy and take-heavy bursts, a few ignored segments
    task automatic run_random(int n_items);
        syn_req_t r;
        int       done;
        int       arrive_pct;
        done = 0;
        while (done < n_items) begin
            arrive_pct = ((done / 16) % 2) ? 70 : 35;
            r = rand_req();
            if ($urandom_range(99) < 8) begin
                r.op = tsbq_pkg::OP_ARRIVE;
                if ($urandom_range(1) == 1)
                    r.flags[tsbq_pkg::SYN_BIT_POS] = 1'b0;
                else
                    r.port = 16'd0;
            end else begin
                if ($urandom_range(99) < arrive_pct) begin
                    r.op = tsbq_pkg::OP_ARRIVE;
                    r.flags[tsbq_pkg::SYN_BIT_POS] = 1'b1;
                    if (r.port == 16'd0)
                        r.port = 16'd1;
                end else begin
                    r.op = tsbq_pkg::OP_TAKE;
                end
            end
            done++;
            send_req(r, 1'b0, '0);
        end
    endtask

    // Receiver: random backpressure, plus one long hold on request
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= LONG_HOLD;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_gap_pct);
        end
    end

    // Result checker: each result word against the oldest prediction
    always @(posedge aclk) begin
        backlog_res_t got;
        backlog_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.accepted = m_tdata[tsbq_pkg::OUT_ACC_LSB];
            got.stored   = m_tdata[tsbq_pkg::OUT_STO_LSB];
            got.found    = m_tdata[tsbq_pkg::OUT_FND_LSB];
            got.port     = m_tdata[tsbq_pkg::OUT_PORT_LSB +: 16];
            got.addr     = m_tdata[tsbq_pkg::OUT_ADDR_LSB +: 32];
            got.rcv_next = m_tdata[tsbq_pkg::OUT_RCV_LSB +: 32];
            got.mss      = m_tdata[tsbq_pkg::OUT_MSS_LSB +: 16];
            if (awaited_replies.size() == 0) begin
                $display("%0t: result word with none expected, actual %0h",
                         $realtime, got);
                mismatch_count++;
            end else begin
                want = awaited_replies.pop_front();
                field_check("accepted", 32'(want.accepted), 32'(got.accepted));
                field_check("stored", 32'(want.stored), 32'(got.stored));
                field_check("found", 32'(want.found), 32'(got.found));
                field_check("out_port", 32'(want.port), 32'(got.port));
                field_check("out_addr", want.addr, got.addr);
                field_check("out_rcv_next", want.rcv_next, got.rcv_next);
                field_check("out_mss", 32'(want.mss), 32'(got.mss));
            end
        end
    end

    // Watchdog: too long without any word moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("%0t: no traffic for %0d cycles", $realtime, QUIET_MAX);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        wr_slot = 0;
        for (int i = 0; i < RING_SLOTS; i++) begin
            ring_port[i] = '0; ring_addr[i] = '0; ring_rcv_next[i] = '0; ring_mss[i] = '0;
        end

        // Directed table: typed results for reset state, extremes and drops
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_TAKE, 8'h00, 16'd0, 32'd0, 32'd0, 1'b0, 16'd0),
                            1'b1, mk_res(1'b0, 1'b0, 1'b0, 16'd0, 32'd0, 32'd0, 16'd0)});
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_ARRIVE, 8'h00, 16'd1, 32'd1, 32'd1,
                                   1'b1, 16'd1),
                            1'b1, mk_res(1'b0, 1'b0, 1'b0, 16'd0, 32'd0, 32'd0, 16'd0)});
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_ARRIVE, 8'hFD, 16'hFFFF, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 1'b1, 16'hFFFF),
                            1'b1, mk_res(1'b0, 1'b0, 1'b0, 16'd0, 32'd0, 32'd0, 16'd0)});
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_ARRIVE, 8'h02, 16'd0, 32'h0A00_0001, 32'd5,
                                   1'b1, 16'd536),
                            1'b1, mk_res(1'b0, 1'b0, 1'b0, 16'd0, 32'd0, 32'd0, 16'd0)});
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_ARRIVE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 1'b1, 16'hFFFF),
                            1'b1, mk_res(1'b1, 1'b1, 1'b0, 16'd0, 32'd0, 32'd0, 16'd0)});
        // sequence wraps to zero
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_TAKE, 8'h00, 16'd0, 32'd0, 32'd0, 1'b0, 16'd0),
                            1'b1, mk_res(1'b0, 1'b0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'd0,
                                         16'hFFFF)});
        // no MSS option: stored size is zero
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_ARRIVE, 8'h02, 16'd1, 32'd0, 32'd0,
                                   1'b0, 16'hFFFF),
                            1'b1, mk_res(1'b1, 1'b1, 1'b0, 16'd0, 32'd0, 32'd0, 16'd0)});
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_ARRIVE, 8'h12, 16'd2, 32'hC0A8_0002,
                                   32'h1234_5678, 1'b1, 16'd0), 1'b0, backlog_res_t'('0)});
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_ARRIVE, 8'h03, 16'd3, 32'hC0A8_0003,
                                   32'h8000_0000, 1'b1, 16'd1460), 1'b0, backlog_res_t'('0)});
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_ARRIVE, 8'h02, 16'd4, 32'hC0A8_0004,
                                   32'h7FFF_FFFF, 1'b0, 16'd1460), 1'b0, backlog_res_t'('0)});
        // ring full: target slot occupied, word dropped
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_ARRIVE, 8'h02, 16'd5, 32'hC0A8_0005, 32'd9,
                                   1'b1, 16'd9),
                            1'b1, mk_res(1'b1, 1'b0, 1'b0, 16'd0, 32'd0, 32'd0, 16'd0)});
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_TAKE, 8'hFF, 16'hFFFF, 32'd0, 32'd0,
                                   1'b1, 16'd0),
                            1'b0, backlog_res_t'('0)});
        // freed slot is not the target one: still dropped
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_ARRIVE, 8'h02, 16'd6, 32'hC0A8_0006, 32'd6,
                                   1'b1, 16'd6),
                            1'b0, backlog_res_t'('0)});
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_TAKE, 8'h00, 16'd0, 32'd0, 32'd0, 1'b0, 16'd0),
                            1'b0, backlog_res_t'('0)});
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_TAKE, 8'h00, 16'd0, 32'd0, 32'd0, 1'b0, 16'd0),
                            1'b0, backlog_res_t'('0)});
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_TAKE, 8'h00, 16'd0, 32'd0, 32'd0, 1'b0, 16'd0),
                            1'b0, backlog_res_t'('0)});
        // ring empty again
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_TAKE, 8'h00, 16'd0, 32'd0, 32'd0, 1'b0, 16'd0),
                            1'b1, mk_res(1'b0, 1'b0, 1'b0, 16'd0, 32'd0, 32'd0, 16'd0)});
        dir_tab.push_back('{mk_req(tsbq_pkg::OP_TAKE, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 1'b1, 16'hFFFF),
                            1'b1, mk_res(1'b0, 1'b0, 1'b0, 16'd0, 32'd0, 32'd0, 16'd0)});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase 1: sender idles lightly, receiver heavily
        tx_gap_pct = 24;
        rx_gap_pct = 78;
        foreach (dir_tab[i])
            send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].res);
        run_random(162);

        // Phase 2: the other way round
        tx_gap_pct = 78;
        rx_gap_pct = 24;
        run_random(160);

        // Phase 3: no idling; receiver first holds off long enough to back up the input
        tx_gap_pct = 0;
        rx_gap_pct = 0;
        hold_req   = 1'b1;
        run_random(160);
        s_tvalid <= 1'b0;

        while (awaited_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
